### src/udsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udsw_pkg
// types, constants and the segment decoder shared by the stopwatch modules
// ----------------------------------------------------------------------------
package udsw_pkg;

   localparam logic [7:0]  TOP_AT_RESET = 8'd124;
   localparam logic [15:0] MS_LAST      = 16'd59999;
   localparam logic [9:0]  SUB_LAST     = 10'd999;
   localparam logic [3:0]  ONES_LAST    = 4'd9;
   localparam logic [2:0]  TENS_LAST    = 3'd5;

   // button positions in the pressed vectors
   localparam int unsigned BTN_START = 0;
   localparam int unsigned BTN_SWAP  = 1;
   localparam int unsigned BTN_CLEAR = 2;

   // segment patterns, bit0 = a .. bit6 = g
   localparam logic [6:0] SEG_0 = 7'h3F;
   localparam logic [6:0] SEG_1 = 7'h06;
   localparam logic [6:0] SEG_2 = 7'h5B;
   localparam logic [6:0] SEG_3 = 7'h4F;
   localparam logic [6:0] SEG_4 = 7'h66;
   localparam logic [6:0] SEG_5 = 7'h6D;
   localparam logic [6:0] SEG_6 = 7'h7D;
   localparam logic [6:0] SEG_7 = 7'h07;
   localparam logic [6:0] SEG_8 = 7'h7F;
   localparam logic [6:0] SEG_9 = 7'h67;
   localparam logic [6:0] SEG_BLANK = 7'h00;

   typedef struct packed {
      logic tick;
      logic start_stop_level;
      logic swap_level;
      logic clear_level;
   } item_type;

   typedef struct packed {
      logic [15:0] ms_value;
      logic [3:0]  ones;
      logic [2:0]  tens;
   } count_type;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      unique case (digit)
         4'd0: pat = SEG_0;
         4'd1: pat = SEG_1;
         4'd2: pat = SEG_2;
         4'd3: pat = SEG_3;
         4'd4: pat = SEG_4;
         4'd5: pat = SEG_5;
         4'd6: pat = SEG_6;
         4'd7: pat = SEG_7;
         4'd8: pat = SEG_8;
         4'd9: pat = SEG_9;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage
`default_nettype wire

### src/udsw_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udsw_counter
// button edges, prescaler and millisecond count with running seconds digits
// ----------------------------------------------------------------------------
module udsw_counter (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           tick_top,
   input  wire logic                 fire,
   input  wire udsw_pkg::item_type   item,
   output udsw_pkg::count_type       count
);

   logic [7:0]  prescale_ff, prescale_in;
   logic [15:0] ms_ff, ms_in;
   logic [9:0]  sub_ff, sub_in;
   logic [3:0]  ones_ff, ones_in;
   logic [2:0]  tens_ff, tens_in;
   logic        running_ff, running_in;
   logic        ascending_ff, ascending_in;
   logic [2:0]  prev_ff, prev_in;

   always_comb begin
      logic [2:0] pressed;
      logic [2:0] press_edge;
      pressed = 3'b000;
      pressed[udsw_pkg::BTN_START] = ~item.start_stop_level;
      pressed[udsw_pkg::BTN_SWAP]  = ~item.swap_level;
      pressed[udsw_pkg::BTN_CLEAR] = ~item.clear_level;
      press_edge = pressed & ~prev_ff;

      prev_in      = pressed;
      running_in   = running_ff ^ press_edge[udsw_pkg::BTN_START];
      ascending_in = ascending_ff ^ press_edge[udsw_pkg::BTN_SWAP];
      prescale_in  = press_edge[udsw_pkg::BTN_SWAP] ? (tick_top - prescale_ff) : prescale_ff;
      ms_in   = ms_ff;
      sub_in  = sub_ff;
      ones_in = ones_ff;
      tens_in = tens_ff;

      if (press_edge[udsw_pkg::BTN_CLEAR]) begin
         prescale_in = 8'd0;
         ms_in   = 16'd0;
         sub_in  = 10'd0;
         ones_in = 4'd0;
         tens_in = 3'd0;
      end

      if (running_in && item.tick) begin
         if (prescale_in >= tick_top) begin
            prescale_in = 8'd0;
            if (ascending_in) begin
               if (ms_in >= udsw_pkg::MS_LAST) begin
                  ms_in   = 16'd0;
                  sub_in  = 10'd0;
                  ones_in = 4'd0;
                  tens_in = 3'd0;
               end else begin
                  ms_in = ms_in + 16'd1;
                  if (sub_in == udsw_pkg::SUB_LAST) begin
                     sub_in = 10'd0;
                     if (ones_in == udsw_pkg::ONES_LAST) begin
                        ones_in = 4'd0;
                        tens_in = tens_in + 3'd1;
                     end else begin
                        ones_in = ones_in + 4'd1;
                     end
                  end else begin
                     sub_in = sub_in + 10'd1;
                  end
               end
            end else begin
               if (ms_in == 16'd0 || ms_in > udsw_pkg::MS_LAST) begin
                  ms_in   = udsw_pkg::MS_LAST;
                  sub_in  = udsw_pkg::SUB_LAST;
                  ones_in = udsw_pkg::ONES_LAST;
                  tens_in = udsw_pkg::TENS_LAST;
               end else begin
                  ms_in = ms_in - 16'd1;
                  if (sub_in == 10'd0) begin
                     sub_in = udsw_pkg::SUB_LAST;
                     if (ones_in == 4'd0) begin
                        ones_in = udsw_pkg::ONES_LAST;
                        tens_in = tens_in - 3'd1;
                     end else begin
                        ones_in = ones_in - 4'd1;
                     end
                  end else begin
                     sub_in = sub_in - 10'd1;
                  end
               end
            end
         end else begin
            prescale_in = prescale_in + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff  <= 8'd0;
         ms_ff        <= 16'd0;
         sub_ff       <= 10'd0;
         ones_ff      <= 4'd0;
         tens_ff      <= 3'd0;
         running_ff   <= 1'b1;
         ascending_ff <= 1'b1;
         prev_ff      <= 3'b000;
      end else if (fire) begin
         prescale_ff  <= prescale_in;
         ms_ff        <= ms_in;
         sub_ff       <= sub_in;
         ones_ff      <= ones_in;
         tens_ff      <= tens_in;
         running_ff   <= running_in;
         ascending_ff <= ascending_in;
         prev_ff      <= prev_in;
      end
   end

   // the result is the count after this request's update
   assign count.ms_value = ms_in;
   assign count.ones     = ones_in;
   assign count.tens     = tens_in;

   a_digits_track: assert property (@(posedge clock) disable iff (reset)
      {1'b0, ms_ff} == ({14'd0, tens_ff} * 17'd10000 + {13'd0, ones_ff} * 17'd1000
                        + {7'd0, sub_ff}))
      else $error("seconds digits out of step with millisecond count");

   a_ms_range: assert property (@(posedge clock) disable iff (reset)
      ms_ff <= udsw_pkg::MS_LAST && sub_ff <= udsw_pkg::SUB_LAST)
      else $error("millisecond count out of range");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(ms_ff) && $stable(prescale_ff) && $stable(prev_ff))
      else $error("counter state moved without a request");

endmodule
`default_nettype wire

### src/up_down_stopwatch_with_display.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// up_down_stopwatch_with_display
// up/down millisecond stopwatch with a two-digit seconds segment display
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_tick, req_*_level (active low)
//  rsp      out        rsp_valid / rsp_ready  rsp_ms_value, rsp_seg_ones, rsp_seg_tens
//  csr      in         csr_valid / csr_ready  csr_data = tick_top
//
//  one request in and one response out per cycle while the response is not
//  stalled; a taken request is held in the request register, then one pass of
//  counter logic moves it into the response register
//  reset sets tick_top to 124, running, counting up, count and prescaler zero
//  a stalled response leaves the request register free for one more request
//  csr writes are always taken
// ----------------------------------------------------------------------------
module up_down_stopwatch_with_display (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_tick,
   input  wire logic        req_start_stop_level,
   input  wire logic        req_swap_level,
   input  wire logic        req_clear_level,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [15:0] rsp_ms_value,
   output      logic [6:0]  rsp_seg_ones,
   output      logic [6:0]  rsp_seg_tens,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_data
);

   logic [7:0]          tick_top_ff;
   logic                in_valid_ff, in_valid_in;
   udsw_pkg::item_type  in_item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         ms_ff;
   logic [6:0]          seg_ones_ff;
   logic [6:0]          seg_tens_ff;
   logic                out_ready;
   logic                fire;
   logic                req_take;
   udsw_pkg::count_type count;

   // register write port never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_top_ff <= udsw_pkg::TOP_AT_RESET;
      end else if (csr_valid) begin
         tick_top_ff <= csr_data;
      end
   end

   // response register is free when empty or being taken
   assign out_ready = !rsp_valid_ff || rsp_ready;
   // held request moves through the counter logic into the response register
   assign fire      = in_valid_ff && out_ready;
   assign req_ready = !in_valid_ff || out_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.tick             <= req_tick;
         in_item_ff.start_stop_level <= req_start_stop_level;
         in_item_ff.swap_level       <= req_swap_level;
         in_item_ff.clear_level      <= req_clear_level;
      end
   end

   // state update for the held request
   udsw_counter u_counter (
      .clock    (clock),
      .reset    (reset),
      .tick_top (tick_top_ff),
      .fire     (fire),
      .item     (in_item_ff),
      .count    (count)
   );

   // response payload with the seconds digits decoded to segments
   always_ff @(posedge clock) begin
      if (fire) begin
         ms_ff       <= count.ms_value;
         seg_ones_ff <= udsw_pkg::seg_pattern(count.ones);
         seg_tens_ff <= udsw_pkg::seg_pattern({1'b0, count.tens});
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ms_value = ms_ff;
   assign rsp_seg_ones = seg_ones_ff;
   assign rsp_seg_tens = seg_tens_ff;

   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("held request lost while response stalled");

   a_fire_fills: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed request gave no response");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("request refused with empty request register");

endmodule
`default_nettype wire

### test/up_down_stopwatch_with_display_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// up_down_stopwatch_with_display_tb
// drives tick and button requests through the stopwatch with random gaps and
// response stalls, predicts every reading and compares it field by field
// ----------------------------------------------------------------------------
module up_down_stopwatch_with_display_tb;

   localparam int unsigned MS_PER_SEC   = 1000;
   localparam int unsigned QUIET_LIMIT  = 1000;
   localparam int unsigned MAX_PRINTED  = 100;
   // segment patterns for digits 0..9, digit d at bits 7*d +: 7
   localparam logic [69:0] GLYPHS = {udsw_pkg::SEG_9, udsw_pkg::SEG_8, udsw_pkg::SEG_7,
                                     udsw_pkg::SEG_6, udsw_pkg::SEG_5, udsw_pkg::SEG_4,
                                     udsw_pkg::SEG_3, udsw_pkg::SEG_2, udsw_pkg::SEG_1,
                                     udsw_pkg::SEG_0};

   typedef struct packed {
      logic [15:0] ms;
      logic [6:0]  ones;
      logic [6:0]  tens;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_tick = 1'b0;
   logic        req_start_stop_level = 1'b1;
   logic        req_swap_level = 1'b1;
   logic        req_clear_level = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_ms_value;
   logic [6:0]  rsp_seg_ones;
   logic [6:0]  rsp_seg_tens;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'd0;

   // predicted watch state
   logic [7:0]  watch_top = udsw_pkg::TOP_AT_RESET;
   logic [7:0]  watch_prescale = 8'd0;
   logic [15:0] watch_ms = 16'd0;
   logic        watch_running = 1'b1;
   logic        watch_up = 1'b1;
   logic [2:0]  watch_held = 3'b000;

   udsw_pkg::item_type samples_pending[$];
   reading_type        readings_due[$];
   int unsigned samples_queued = 0;
   int unsigned samples_taken = 0;
   int unsigned fault_count = 0;
   int unsigned idle_cycles = 0;

   up_down_stopwatch_with_display dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_tick             (req_tick),
      .req_start_stop_level (req_start_stop_level),
      .req_swap_level       (req_swap_level),
      .req_clear_level      (req_clear_level),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ms_value         (rsp_ms_value),
      .rsp_seg_ones         (rsp_seg_ones),
      .rsp_seg_tens         (rsp_seg_tens),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic reading_type advance_watch(input udsw_pkg::item_type s);
      logic [2:0]  now_down;
      logic [2:0]  fresh;
      int unsigned secs;
      reading_type shown;
      now_down = 3'b000;
      now_down[udsw_pkg::BTN_START] = !s.start_stop_level;
      now_down[udsw_pkg::BTN_SWAP]  = !s.swap_level;
      now_down[udsw_pkg::BTN_CLEAR] = !s.clear_level;
      fresh = now_down & ~watch_held;
      if (fresh[udsw_pkg::BTN_START]) watch_running = !watch_running;
      if (fresh[udsw_pkg::BTN_SWAP]) begin
         watch_prescale = watch_top - watch_prescale;
         watch_up = !watch_up;
      end
      if (fresh[udsw_pkg::BTN_CLEAR]) begin
         watch_prescale = 8'd0;
         watch_ms = 16'd0;
      end
      watch_held = now_down;
      if (watch_running && s.tick) begin
         if (watch_prescale >= watch_top) begin
            watch_prescale = 8'd0;
            if (watch_up)
               watch_ms = (watch_ms >= udsw_pkg::MS_LAST) ? 16'd0 : watch_ms + 16'd1;
            else
               watch_ms = (watch_ms == 16'd0 || watch_ms > udsw_pkg::MS_LAST)
                          ? udsw_pkg::MS_LAST : watch_ms - 16'd1;
         end else begin
            watch_prescale = watch_prescale + 8'd1;
         end
      end
      secs = (watch_ms / MS_PER_SEC) % 60;
      shown.ms   = watch_ms;
      shown.ones = GLYPHS[(secs % 10) * 7 +: 7];
      shown.tens = GLYPHS[(secs / 10) * 7 +: 7];
      return shown;
   endfunction

   // zero during a calm stretch, otherwise a random pause length
   function automatic int unsigned draw_pause(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 18);
   endfunction

   task automatic flag_fault(input string what);
      fault_count++;
      if (fault_count <= MAX_PRINTED) $display("%0t ns: %s", $time, what);
   endtask

   task automatic queue_levels(input bit t, input bit ss, input bit sw, input bit cl);
      udsw_pkg::item_type s;
      s.tick = t;
      s.start_stop_level = ss;
      s.swap_level = sw;
      s.clear_level = cl;
      samples_pending.push_back(s);
      samples_queued++;
   endtask

   // mostly released buttons with short presses, some raw noise on the levels
   task automatic queue_random(input int unsigned n, input int unsigned press_odds,
                               input int unsigned tick_pct);
      logic [2:0]  down;
      int unsigned hold;
      logic [2:0]  lv;
      down = 3'b000;
      hold = 0;
      repeat (n) begin
         if (hold > 0) begin
            hold--;
         end else if (down != 3'b000) begin
            down = 3'b000;
         end else if ($urandom_range(1, press_odds) == 1) begin
            down = 3'($urandom_range(1, 7));
            if (down[udsw_pkg::BTN_CLEAR] && $urandom_range(0, 2) != 0)
               down[udsw_pkg::BTN_CLEAR] = 1'b0;
            if (down == 3'b000) down[udsw_pkg::BTN_SWAP] = 1'b1;
            hold = $urandom_range(0, 3);
         end
         lv = ~down;
         if ($urandom_range(0, 11) == 0) lv = 3'($urandom_range(0, 7));
         queue_levels($urandom_range(0, 99) < tick_pct,
                      lv[udsw_pkg::BTN_START], lv[udsw_pkg::BTN_SWAP],
                      lv[udsw_pkg::BTN_CLEAR]);
      end
   endtask

   task automatic wait_drained;
      do @(posedge clock);
      while (!(samples_taken == samples_queued && readings_due.size() == 0));
   endtask

   task automatic write_top(input logic [7:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      watch_top = v;
   endtask

   // request driver
   always @(posedge clock) begin : drive
      udsw_pkg::item_type on_wire;
      static int unsigned send_wait = 0;
      static int unsigned send_calm = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            readings_due.push_back(advance_watch(on_wire));
            samples_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (samples_pending.size() > 0) begin
               on_wire = samples_pending.pop_front();
               req_tick             <= on_wire.tick;
               req_start_stop_level <= on_wire.start_stop_level;
               req_swap_level       <= on_wire.swap_level;
               req_clear_level      <= on_wire.clear_level;
               req_valid            <= 1'b1;
               send_wait = draw_pause(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : watch
      reading_type        want;
      static int unsigned take_wait = 0;
      static int unsigned take_calm = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               flag_fault($sformatf("response with nothing expected, ms_value %0d",
                                    rsp_ms_value));
            end else begin
               want = readings_due.pop_front();
               if (rsp_ms_value !== want.ms)
                  flag_fault($sformatf("ms_value got %0d want %0d", rsp_ms_value, want.ms));
               if (rsp_seg_ones !== want.ones)
                  flag_fault($sformatf("seg_ones got %h want %h (ms %0d)",
                                       rsp_seg_ones, want.ones, want.ms));
               if (rsp_seg_tens !== want.tens)
                  flag_fault($sformatf("seg_tens got %h want %h (ms %0d)",
                                       rsp_seg_tens, want.tens, want.ms));
            end
            take_wait = draw_pause(take_calm);
         end
         if (take_wait > 0) begin
            take_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= QUIET_LIMIT) begin
         $display("** up_down_stopwatch_with_display: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: stop and hold, swap, descending wrap, clear, all buttons at once
      queue_levels(0, 1, 1, 1);
      queue_levels(1, 1, 1, 1);
      queue_levels(1, 0, 1, 1);
      queue_levels(1, 0, 1, 1);
      queue_levels(1, 1, 1, 1);
      queue_levels(1, 0, 1, 1);
      queue_levels(0, 1, 0, 1);
      repeat (3) queue_levels(1, 1, 1, 1);
      queue_levels(1, 1, 1, 0);
      queue_levels(0, 0, 0, 0);
      queue_levels(0, 1, 1, 1);
      queue_levels(1, 0, 1, 1);
      queue_levels(0, 1, 1, 1);
      queue_levels(0, 1, 0, 1);
      repeat (2) queue_levels(1, 1, 1, 1);
      queue_levels(0, 1, 1, 1);
      queue_levels(1, 1, 0, 1);
      queue_random(150, 12, 80);
      wait_drained();

      // leave the prescaler well above the next top
      queue_levels(0, 1, 1, 1);
      if (!watch_running) begin
         queue_levels(0, 0, 1, 1);
         queue_levels(0, 1, 1, 1);
      end
      queue_levels(0, 1, 1, 0);
      queue_levels(0, 1, 1, 1);
      repeat (60) queue_levels(1, 1, 1, 1);
      wait_drained();

      // top of one, swap first so the prescaler reflection wraps
      write_top(8'd1);
      queue_levels(0, 1, 0, 1);
      queue_levels(0, 1, 1, 1);
      queue_random(180, 15, 85);
      wait_drained();

      write_top(8'd255);
      queue_random(150, 12, 80);
      wait_drained();

      // top of zero, every tick steps the count
      write_top(8'd0);
      queue_random(300, 60, 95);
      wait_drained();

      write_top(8'($urandom_range(2, 254)));
      queue_random(150, 10, 70);
      wait_drained();

      write_top(udsw_pkg::TOP_AT_RESET);
      queue_random(100, 12, 80);
      wait_drained();

      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("** up_down_stopwatch_with_display: PASSED **");
      else
         $display("** up_down_stopwatch_with_display: FAILED **");
      $finish;
   end

endmodule
